// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the character class run splitter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== rtl/ccrs_pkg.sv =====
// Package of the character class run splitter: widths, codes and class tests.
// Depends on nothing; imported by the interfaces and the core.
`default_nettype none

package ccrs_pkg;

    localparam int SET_SIZE = 32;

    localparam int CP_W    = 21;
    localparam int SEL_W   = 2;
    localparam int IDX_W   = 5;
    localparam int CLASS_W = 2;
    localparam int KIND_W  = 2;

    typedef enum logic {
        OP_LOAD     = 1'b0,
        OP_CLASSIFY = 1'b1
    } t_op;

    typedef enum logic [SEL_W-1:0] {
        SEL_PUNCT      = 2'd0,
        SEL_NUMBER     = 2'd1,
        SEL_NUMBER_END = 2'd2,
        SEL_NONE       = 2'd3
    } t_set_sel;

    typedef enum logic [CLASS_W-1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_ALPHA   = 2'd1,
        CLS_NUMBER  = 2'd2,
        CLS_PUNCT   = 2'd3
    } t_char_class;

    typedef enum logic [KIND_W-1:0] {
        KIND_OTHER  = 2'd0,
        KIND_ALPHA  = 2'd1,
        KIND_NUMBER = 2'd2
    } t_token_kind;

    localparam logic [CP_W-1:0] CP_FULL_STOP = 21'h00002E;

    function automatic logic is_ascii_alpha(input logic [CP_W-1:0] cp);
        return cp inside {[21'h41 : 21'h5A], [21'h61 : 21'h7A]};
    endfunction

    function automatic logic is_ascii_digit(input logic [CP_W-1:0] cp);
        return cp inside {[21'h30 : 21'h39]};
    endfunction

    function automatic logic is_ascii_punct(input logic [CP_W-1:0] cp);
        return cp inside {[21'h21 : 21'h2F], [21'h3A : 21'h40],
                          [21'h5B : 21'h60], [21'h7B : 21'h7E]};
    endfunction

    function automatic t_token_kind kind_of(input t_char_class cls);
        t_token_kind kind;
        case (cls)
            CLS_ALPHA:  kind = KIND_ALPHA;
            CLS_NUMBER: kind = KIND_NUMBER;
            default:    kind = KIND_OTHER;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ccrs_if.sv =====
// Valid/ready channel interfaces for the input and result beats of the splitter.
// Depends on ccrs_pkg for field widths and codes.
`default_nettype none

interface ccrs_in_if;
    import ccrs_pkg::*;

    logic                valid;
    logic                ready;
    t_op                 op;
    t_set_sel            set_select;
    logic [IDX_W-1:0]    entry_index;
    logic                entry_enable;
    logic [CP_W-1:0]     code_point;
    logic                string_last;

    modport source (
        output valid, op, set_select, entry_index, entry_enable, code_point, string_last,
        input  ready
    );
    modport sink (
        input  valid, op, set_select, entry_index, entry_enable, code_point, string_last,
        output ready
    );
endinterface

interface ccrs_out_if;
    import ccrs_pkg::*;

    logic                valid;
    logic                ready;
    logic [CP_W-1:0]     char_out;
    logic                token_start;
    t_token_kind         token_kind;
    t_char_class         run_class;
    logic                token_last;

    modport source (
        output valid, char_out, token_start, token_kind, run_class, token_last,
        input  ready
    );
    modport sink (
        input  valid, char_out, token_start, token_kind, run_class, token_last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/char_class_run_splitter_core.sv =====
// Character class run splitter: classifies code points and marks token starts.
// Depends on ccrs_pkg, the channel interfaces in ccrs_if.sv and assert_macros.svh.
//
// Usage. Beats arrive on i_in. A beat with op set to load writes one slot of the
// punctuation, number or number-end set and yields no result. A beat with op set
// to classify yields exactly one beat on o_out carrying the code point, its class,
// the token kind and a flag that marks the first character of a new token.
// Path: a classify beat is registered in the input stage, classified there and
// written to the result register, from which it is shown on o_out.
// Throughput: one beat per cycle while the receiver takes results, limited only
// by the single result register; the previous class is fed back from a register,
// so back-to-back characters of one string never wait for one another.
// Set lookups compare the code point against all slots of the three sets at once.
// Reset clears all set valid bits, the previous class (to unknown) and sets the
// string-start flag; no clearing pass is needed, so beats are taken right away.
// When the receiver stalls, the result holds on o_out, one further beat may sit
// in the input stage, and i_in.ready falls only once both are occupied. Load
// beats drain from the input stage even while a result waits to be taken.
`default_nettype none
`include "assert_macros.svh"

module char_class_run_splitter_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ccrs_in_if.sink     i_in,
    ccrs_out_if.source  o_out
);
    import ccrs_pkg::*;

    // Input stage register.
    logic              r_s1_valid;
    t_op               r_s1_op;
    t_set_sel          r_s1_sel;
    logic [IDX_W-1:0]  r_s1_idx;
    logic              r_s1_en;
    logic [CP_W-1:0]   r_s1_cp;
    logic              r_s1_last;

    // Set storage: each slot is compared in parallel against the staged code point.
    logic [CP_W-1:0]   r_punct_val  [SET_SIZE];
    logic [CP_W-1:0]   r_num_val    [SET_SIZE];
    logic [CP_W-1:0]   r_numend_val [SET_SIZE];
    logic [SET_SIZE-1:0] r_punct_vld;
    logic [SET_SIZE-1:0] r_num_vld;
    logic [SET_SIZE-1:0] r_numend_vld;

    // Run state carried from one character to the next.
    t_char_class       r_prev_class;
    logic              r_at_start;

    // Result register.
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    logic              r_out_start;
    t_token_kind       r_out_kind;
    t_char_class       r_out_class;
    logic              r_out_last;

    logic              s1_go;
    logic              s1_classify;
    logic              s1_load;
    logic              in_fire;
    logic [SET_SIZE-1:0] punct_hit;
    logic [SET_SIZE-1:0] num_hit;
    logic [SET_SIZE-1:0] numend_hit;
    t_char_class       prev_eff;
    t_char_class       n_class;
    logic              n_start;

    assign s1_classify = r_s1_valid && (r_s1_op == OP_CLASSIFY);
    assign s1_load     = r_s1_valid && (r_s1_op == OP_LOAD);

    // A load leaves the input stage at once; a classify beat needs room in the
    // result register.
    assign s1_go   = s1_load || (s1_classify && (!r_out_valid || o_out.ready));
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op   <= i_in.op;
            r_s1_sel  <= i_in.set_select;
            r_s1_idx  <= i_in.entry_index;
            r_s1_en   <= i_in.entry_enable;
            r_s1_cp   <= i_in.code_point;
            r_s1_last <= i_in.string_last;
        end
    end

    // Set loads. An index beyond the set size or an unused select writes nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_punct_vld  <= '0;
            r_num_vld    <= '0;
            r_numend_vld <= '0;
        end else if (s1_load) begin
            for (int i = 0; i < SET_SIZE; i++) begin
                if (32'(r_s1_idx) == i) begin
                    case (r_s1_sel)
                        SEL_PUNCT:      r_punct_vld[i]  <= r_s1_en;
                        SEL_NUMBER:     r_num_vld[i]    <= r_s1_en;
                        SEL_NUMBER_END: r_numend_vld[i] <= r_s1_en;
                        default:        ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            for (int i = 0; i < SET_SIZE; i++) begin
                if (32'(r_s1_idx) == i) begin
                    case (r_s1_sel)
                        SEL_PUNCT:      r_punct_val[i]  <= r_s1_cp;
                        SEL_NUMBER:     r_num_val[i]    <= r_s1_cp;
                        SEL_NUMBER_END: r_numend_val[i] <= r_s1_cp;
                        default:        ;
                    endcase
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SET_SIZE; i++) begin
            punct_hit[i]  = r_punct_vld[i]  && (r_punct_val[i]  == r_s1_cp);
            num_hit[i]    = r_num_vld[i]    && (r_num_val[i]    == r_s1_cp);
            numend_hit[i] = r_numend_vld[i] && (r_numend_val[i] == r_s1_cp);
        end
    end

    // At the start of a string the previous character counts as unknown. The
    // tests are taken in priority order, the full stop check ahead of punctuation.
    assign prev_eff = r_at_start ? CLS_UNKNOWN : r_prev_class;

    always_comb begin
        if (is_ascii_alpha(r_s1_cp)) begin
            n_class = CLS_ALPHA;
        end else if (is_ascii_digit(r_s1_cp)) begin
            n_class = CLS_NUMBER;
        end else if ((r_s1_cp == CP_FULL_STOP) && (prev_eff == CLS_NUMBER)) begin
            n_class = CLS_NUMBER;
        end else if ((|punct_hit) || is_ascii_punct(r_s1_cp)) begin
            n_class = CLS_PUNCT;
        end else if (|num_hit) begin
            n_class = CLS_NUMBER;
        end else if ((|numend_hit) && (prev_eff == CLS_NUMBER)) begin
            n_class = CLS_NUMBER;
        end else begin
            n_class = CLS_UNKNOWN;
        end
    end

    // The class change test uses the stored class even across a string boundary;
    // the string-start flag forces a token start there anyway.
    assign n_start = r_at_start || (n_class != r_prev_class);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_class <= CLS_UNKNOWN;
            r_at_start   <= 1'b1;
        end else if (s1_go && s1_classify) begin
            r_prev_class <= n_class;
            r_at_start   <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_classify) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_classify) begin
            r_out_cp    <= r_s1_cp;
            r_out_start <= n_start;
            r_out_kind  <= kind_of(n_class);
            r_out_class <= n_class;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.char_out    = r_out_cp;
    assign o_out.token_start = r_out_start;
    assign o_out.token_kind  = r_out_kind;
    assign o_out.run_class   = r_out_class;
    assign o_out.token_last  = r_out_last;

    // A load beat never produces a result.
    `ASSERT_NEXT(a_load_no_result, i_clk, i_rst_n, s1_load && !s1_classify && !r_out_valid, !r_out_valid)
    // The first character of a string always opens a token.
    `ASSERT_NEXT(a_string_start_token, i_clk, i_rst_n, s1_go && s1_classify && r_at_start, r_out_valid && r_out_start)
    // Token kind and class agree on every shown result.
    `ASSERT_SAME(a_kind_matches_class, i_clk, i_rst_n, r_out_valid, (r_out_kind == KIND_NUMBER) == (r_out_class == CLS_NUMBER) && (r_out_kind == KIND_ALPHA) == (r_out_class == CLS_ALPHA))

endmodule

`default_nettype wire

// ===== tb/ccrs_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the character class run splitter testbench: class prediction and result checks.
// Depends on ccrs_pkg for field widths, set selects, classes and token kinds.

package ccrs_tb_pkg;
    import ccrs_pkg::*;

    typedef struct packed {
        logic [CP_W-1:0] char_out;
        logic            token_start;
        t_token_kind     token_kind;
        t_char_class     run_class;
        logic            token_last;
    } t_class_result;

    class run_split_checker;
        t_char_class     last_class;
        bit              in_string_head;
        bit              slot_valid [3][SET_SIZE];
        logic [CP_W-1:0] slot_cp    [3][SET_SIZE];
        t_class_result   awaited_chars [$];
        int unsigned     mismatches;
        int unsigned     chars_noted;
        int unsigned     loads_noted;
        int unsigned     results_checked;
        int unsigned     tokens_begun;

        function new();
            last_class      = CLS_UNKNOWN;
            in_string_head  = 1'b1;
            mismatches      = 0;
            chars_noted     = 0;
            loads_noted     = 0;
            results_checked = 0;
            tokens_begun    = 0;
            foreach (slot_valid[s, i]) begin
                slot_valid[s][i] = 1'b0;
                slot_cp[s][i]    = '0;
            end
        endfunction

        function bit set_holds(t_set_sel sel, logic [CP_W-1:0] cp);
            bit hit;
            hit = 1'b0;
            for (int i = 0; i < SET_SIZE; i++)
                if (slot_valid[int'(sel)][i] && slot_cp[int'(sel)][i] == cp)
                    hit = 1'b1;
            return hit;
        endfunction

        // The tests are ordered: a full stop after a number wins over punctuation.
        function t_char_class class_of_char(logic [CP_W-1:0] cp, t_char_class prior);
            if ((cp >= 'h41 && cp <= 'h5A) || (cp >= 'h61 && cp <= 'h7A))
                return CLS_ALPHA;
            if (cp >= 'h30 && cp <= 'h39)
                return CLS_NUMBER;
            if (cp == CP_FULL_STOP && prior == CLS_NUMBER)
                return CLS_NUMBER;
            if (set_holds(SEL_PUNCT, cp) ||
                (cp >= 'h21 && cp <= 'h2F) || (cp >= 'h3A && cp <= 'h40) ||
                (cp >= 'h5B && cp <= 'h60) || (cp >= 'h7B && cp <= 'h7E))
                return CLS_PUNCT;
            if (set_holds(SEL_NUMBER, cp))
                return CLS_NUMBER;
            if (set_holds(SEL_NUMBER_END, cp) && prior == CLS_NUMBER)
                return CLS_NUMBER;
            return CLS_UNKNOWN;
        endfunction

        function void note_beat(t_op op, t_set_sel sel, logic [IDX_W-1:0] idx, logic en,
                                logic [CP_W-1:0] cp, logic last);
            t_char_class   prior;
            t_char_class   cls;
            t_class_result want;
            if (op == OP_LOAD) begin
                if (sel != SEL_NONE && idx < SET_SIZE) begin
                    slot_valid[int'(sel)][idx] = en;
                    slot_cp[int'(sel)][idx]    = cp;
                    loads_noted++;
                end
                return;
            end
            prior = in_string_head ? CLS_UNKNOWN : last_class;
            cls   = class_of_char(cp, prior);
            want.char_out    = cp;
            want.token_start = in_string_head || cls != last_class;
            want.token_kind  = (cls == CLS_ALPHA)  ? KIND_ALPHA  :
                               (cls == CLS_NUMBER) ? KIND_NUMBER : KIND_OTHER;
            want.run_class   = cls;
            want.token_last  = last;
            awaited_chars.insert(awaited_chars.size(), want);
            last_class     = cls;
            in_string_head = last;
            chars_noted++;
        endfunction

        function void check_result(t_class_result got);
            t_class_result want;
            if (awaited_chars.size() == 0) begin
                $error("unexpected result beat: char_out %0h", got.char_out);
                mismatches++;
                return;
            end
            want = awaited_chars.pop_front();
            results_checked++;
            if (got.token_start === 1'b1)
                tokens_begun++;
            if (got.char_out !== want.char_out) begin
                $error("char_out: expected %0h, got %0h", want.char_out, got.char_out);
                mismatches++;
            end
            if (got.token_start !== want.token_start) begin
                $error("token_start: expected %0b, got %0b", want.token_start, got.token_start);
                mismatches++;
            end
            if (got.token_kind !== want.token_kind) begin
                $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
                mismatches++;
            end
            if (got.run_class !== want.run_class) begin
                $error("run_class: expected %0d, got %0d", want.run_class, got.run_class);
                mismatches++;
            end
            if (got.token_last !== want.token_last) begin
                $error("token_last: expected %0b, got %0b", want.token_last, got.token_last);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited_chars.size();
        endfunction
    endclass

endpackage

// ===== tb/char_class_run_splitter_core_tb.sv =====
`timescale 1ns / 1ps
// Top-level testbench of char_class_run_splitter_core: drives character and set-load beats.
// Depends on ccrs_pkg, the channel interfaces in ccrs_if.sv and the scoreboard in ccrs_tb_pkg.

module char_class_run_splitter_core_tb;
    import ccrs_pkg::*;
    import ccrs_tb_pkg::*;

    // Number of counted input beats in the random part, the length of the forced
    // receiver hold-off, the quiet tail after draining and the watchdog limit.
    localparam int          RANDOM_BEATS = 1800;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          TAIL_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ccrs_in_if  in_ch ();
    ccrs_out_if out_ch ();

    char_class_run_splitter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    run_split_checker run_tracker = new();

    // Code points that the set loads draw from, so that classified characters
    // hit loaded slots often. Some of them clash on purpose with the fixed
    // tests: a full stop, a letter, a code point beyond the Unicode range and
    // the all-ones value.
    logic [CP_W-1:0] glyph_pool [13] = '{
        21'h000660, 21'h000669, 21'h00066B, 21'h00066C, 21'h0000A7, 21'h0000B6,
        21'h002030, 21'h003001, 21'h110000, 21'h1FFFFF, 21'h000000, 21'h00002E,
        21'h000041
    };

    // Handshake between the stimulus and the result sink. The stimulus raises
    // hold_request to ask for one long hold-off, steady_tx removes the sender's
    // gaps and steady_rx removes the receiver's stalls.
    bit          hold_request = 1'b0;
    bit          steady_tx    = 1'b0;
    bit          steady_rx    = 1'b0;
    int unsigned beats_counted;
    int unsigned cycle_count = 0;

    // The clock: 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Most gaps are zero or short; a few are long so that the pipeline empties
    // completely between beats now and then.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A character for a random string. The mix leans on letters, digits and the
    // full stop so that number runs, and what follows them, are frequent.
    function automatic logic [CP_W-1:0] pick_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return CP_W'($urandom_range(0, 1) ? $urandom_range('h41, 'h5A)
                                              : $urandom_range('h61, 'h7A));
        if (r < 40)
            return CP_W'($urandom_range('h30, 'h39));
        if (r < 50)
            return CP_FULL_STOP;
        if (r < 60)
            return CP_W'($urandom_range('h21, 'h7E));
        if (r < 78)
            return glyph_pool[$urandom_range(0, 12)];
        if (r < 88)
            return CP_W'($urandom_range(0, 1) ? $urandom_range(0, 'h20) : 'h7F);
        return CP_W'($urandom_range(0, 'h1FFFFF));
    endfunction

    // Offer one beat and hold it until the block takes it. Ready is sampled at
    // the edge, before any register of the block updates, so the decision does
    // not depend on process order. Valid stays high on return; only a gap or a drain
    // lowers it, so it never gets two assignments in one time step.
    task automatic send_beat(input t_op op, input t_set_sel sel, input logic [IDX_W-1:0] idx,
                             input logic en, input logic [CP_W-1:0] cp, input logic last);
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.set_select   <= sel;
        in_ch.entry_index  <= idx;
        in_ch.entry_enable <= en;
        in_ch.code_point   <= cp;
        in_ch.string_last  <= last;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);
        run_tracker.note_beat(op, sel, idx, en, cp, last);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // A classify beat carries random values in the fields that only a load
    // uses, so that those bits toggle without effect.
    task automatic send_char(input logic [CP_W-1:0] cp, input logic last);
        send_beat(OP_CLASSIFY, t_set_sel'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)), cp, last);
        beats_counted++;
        pause_sender(steady_tx ? 0 : pick_gap());
    endtask

    // A load with the unused select is ignored by the block and is not counted.
    task automatic send_load(input t_set_sel sel, input logic [IDX_W-1:0] idx, input logic en,
                             input logic [CP_W-1:0] cp);
        send_beat(OP_LOAD, sel, idx, en, cp, 1'($urandom_range(0, 1)));
        if (sel != SEL_NONE)
            beats_counted++;
        pause_sender(steady_tx ? 0 : pick_gap());
    endtask

    // Valid drops and the task waits until every predicted result has been checked.
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (run_tracker.outstanding() != 0);
    endtask

    // One string of random length made of random characters; now and then a
    // set load lands in the middle of it, which must not disturb the run.
    task automatic send_string();
        int len;
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 5)
                send_load(t_set_sel'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 31)),
                          $urandom_range(0, 3) != 0, glyph_pool[$urandom_range(0, 12)]);
            send_char(pick_char(), k == len - 1);
        end
    endtask

    // Result sink: checks every accepted result beat and drives ready with
    // random stalls. A request for a hold-off is served here and counted down
    // in this process, while the stimulus keeps offering beats.
    initial begin : result_sink
        int            stall_left;
        t_class_result got;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.char_out    = out_ch.char_out;
                got.token_start = out_ch.token_start;
                got.token_kind  = out_ch.token_kind;
                got.run_class   = out_ch.run_class;
                got.token_last  = out_ch.token_last;
                run_tracker.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (steady_rx) begin
                out_ch.ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        bit hold_done;
        bit drain_done;
        hold_done          = 1'b0;
        drain_done         = 1'b0;
        beats_counted      = 0;
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_LOAD;
        in_ch.set_select   = SEL_PUNCT;
        in_ch.entry_index  = '0;
        in_ch.entry_enable = 1'b0;
        in_ch.code_point   = '0;
        in_ch.string_last  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Loads first: both ends of the slot range, a cleared
        // slot and a load with the unused select, which must change nothing.
        send_load(SEL_PUNCT,      5'd0,  1'b1, 21'h0000A7);
        send_load(SEL_PUNCT,      5'd31, 1'b1, 21'h1FFFFF);
        send_load(SEL_PUNCT,      5'd3,  1'b0, 21'h0000B6);
        send_load(SEL_NONE,       5'd7,  1'b1, 21'h0000B6);
        send_load(SEL_NUMBER,     5'd5,  1'b1, 21'h000663);
        send_load(SEL_NUMBER_END, 5'd2,  1'b1, 21'h00066B);

        // A full stop right after a digit stays in the number run.
        send_char(21'h000041, 1'b0);
        send_char(21'h000039, 1'b0);
        send_char(CP_FULL_STOP, 1'b0);
        send_char(21'h00007A, 1'b1);
        // At the start of a string a full stop is plain punctuation, and a
        // number-end member is unknown.
        send_char(CP_FULL_STOP, 1'b1);
        send_char(21'h00066B, 1'b0);
        send_char(21'h000030, 1'b0);
        send_char(21'h00066B, 1'b0);
        send_char(21'h000663, 1'b0);
        send_char(21'h0000A7, 1'b0);
        // All-ones code point is a set member here; the cleared slot and the
        // ignored load leave 0xB6 unknown; code point zero does not end a string.
        send_char(21'h1FFFFF, 1'b0);
        send_char(21'h0000B6, 1'b0);
        send_char(21'h000000, 1'b0);
        send_char(21'h00007E, 1'b1);
        send_char(21'h00005A, 1'b0);
        send_char(21'h000061, 1'b0);
        send_char(21'h000021, 1'b1);

        // Random part: mostly strings, some loads and a little noise. Phases
        // with no sender gaps or no receiver stalls are woven in, along with one
        // long hold-off and one full drain.
        beats_counted = 0;
        while (beats_counted < RANDOM_BEATS) begin
            steady_tx = (beats_counted >= 300 && beats_counted < 450);
            steady_rx = (beats_counted >= 1400 && beats_counted < 1550);
            if (!hold_done && beats_counted >= 600) begin
                // The block fills up behind the held receiver and must stall
                // its input; the sender keeps offering without gaps.
                hold_done    = 1'b1;
                hold_request = 1'b1;
                steady_tx    = 1'b1;
                repeat (4) send_string();
                steady_tx    = 1'b0;
            end
            if (!drain_done && beats_counted >= 1100) begin
                drain_done = 1'b1;
                wait_for_drain();
            end
            if ($urandom_range(0, 99) < 10) begin
                send_load(t_set_sel'($urandom_range(0, 99) < 5 ? 3 : $urandom_range(0, 2)),
                          IDX_W'($urandom_range(0, 31)), $urandom_range(0, 4) != 0,
                          CP_W'($urandom_range(0, 99) < 85 ? glyph_pool[$urandom_range(0, 12)]
                                                           : $urandom_range(0, 'h1FFFFF)));
            end else if ($urandom_range(0, 99) < 8) begin
                send_char(CP_W'($urandom_range(0, 'h1FFFFF)), 1'($urandom_range(0, 1)));
            end else begin
                send_string();
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d characters against the prediction, %0d set loads applied.",
                 run_tracker.results_checked, run_tracker.loads_noted);
        $display("%0d tokens began; %0d field mismatches in %0d cycles.",
                 run_tracker.tokens_begun, run_tracker.mismatches, cycle_count);
        if (run_tracker.mismatches == 0 && run_tracker.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
